[rtl/led2w_pkg.sv]
`default_nettype none

package led2w_pkg;

  // Item kinds on the request channel.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_NUMBER = 2'd2;
  localparam logic [1:0] KIND_BRIGHT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SHORT_DELAY = 2'd0;
  localparam logic [1:0] CFG_LONG_DELAY  = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  localparam logic [7:0] SHORT_DELAY_RST = 8'd1;
  localparam logic [7:0] LONG_DELAY_RST  = 8'd4;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd250;

  // Display driver addresses.
  localparam logic [7:0] ADDR_DIG_THOUSANDS = 8'h6C;
  localparam logic [7:0] ADDR_DIG_HUNDREDS  = 8'h6A;
  localparam logic [7:0] ADDR_DIG_TENS      = 8'h68;
  localparam logic [7:0] ADDR_DIG_ONES      = 8'h6E;
  localparam logic [7:0] ADDR_CONTROL       = 8'h48;
  localparam logic [3:0] CONTROL_LOW_BITS   = 4'h5;

  localparam int unsigned NUM_DIGITS = 4;

  // Bus sequencer phases, one-hot.
  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_START_A   = 11'b000_0000_0010,
    PH_START_B   = 11'b000_0000_0100,
    PH_BIT_SETUP = 11'b000_0000_1000,
    PH_BIT_HIGH  = 11'b000_0001_0000,
    PH_BIT_LOW   = 11'b000_0010_0000,
    PH_ACK_REL   = 11'b000_0100_0000,
    PH_ACK_HIGH  = 11'b000_1000_0000,
    PH_ACK_POLL  = 11'b001_0000_0000,
    PH_STOP_A    = 11'b010_0000_0000,
    PH_STOP_B    = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic scl_level;
    logic sda_release;
    logic busy_res;
    logic ack_timeout;
    logic request_done;
    logic rejected;
  } result_t;

  // Seven-segment pattern of one decimal digit.
  function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hF5;
      4'd1:    seg = 8'h84;
      4'd2:    seg = 8'hB3;
      4'd3:    seg = 8'h97;
      4'd4:    seg = 8'hC6;
      4'd5:    seg = 8'h57;
      4'd6:    seg = 8'h77;
      4'd7:    seg = 8'h85;
      4'd8:    seg = 8'hF7;
      4'd9:    seg = 8'hD7;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[rtl/led_display_two_wire_writer.sv]
// The result word of an accepted input word is registered. Throughput: one input word per
// cycle while in_stall_o is low; the sequencer state and the result register update
// together, and a skid register takes one result while the output is stalled.
// Reset (asynchronous, active low): sequencer idle, no output word valid, queue empty, counters
// cleared, delay registers back to 1 and 4 ticks, poll limit back to 250. Queue entries are not cleared.
`default_nettype none

module led_display_two_wire_writer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  address_byte_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [13:0] number_value_i,
  input  wire logic [2:0]  brightness_level_i,
  input  wire logic        sda_sample_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        scl_level_o,
  output      logic        sda_release_o,
  output      logic        busy_res_o,
  output      logic        ack_timeout_o,
  output      logic        request_done_o,
  output      logic        rejected_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import led2w_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration.
  logic [7:0] short_delay_q, long_delay_q, poll_limit_q;

  // Sequencer state.
  phase_e            phase_q, phase_d;
  logic [2:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic              byte_sel_q, byte_sel_d;
  logic [7:0]        delay_q, delay_d;
  logic [7:0]        poll_q, poll_d;
  logic [7:0]        data_cur_q, data_cur_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [15:0]       queue_q [QUEUE_DEPTH];
  logic [15:0]       queue_d [QUEUE_DEPTH];

  // Output register and skid stage.
  result_t out_q, skid_q, res_d;
  logic    out_valid_q, skid_valid_q;

  logic accept, out_fire;
  logic busy_now, timeout_d, done_d, rej_d;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  // Decimal digits by reciprocal multiplication; each quotient is floor-exact over 14 bits.
  logic [28:0] prod_k, prod_h;
  logic [29:0] prod_t;
  logic [4:0]  quo_k;
  logic [7:0]  quo_h;
  logic [10:0] quo_t;
  logic [3:0]  dig_k, dig_h, dig_t, dig_o;
  logic [7:0]  diff_h;
  logic [10:0] diff_t;
  logic [13:0] diff_o;

  assign prod_k = 29'(number_value_i) * 29'd16778;
  assign prod_h = 29'(number_value_i) * 29'd20972;
  assign prod_t = 30'(number_value_i) * 30'd52429;
  assign quo_k  = prod_k[28:24];
  assign quo_h  = prod_h[28:21];
  assign quo_t  = prod_t[29:19];

  assign dig_k  = (quo_k >= 5'd10) ? 4'(quo_k - 5'd10) : quo_k[3:0];
  assign diff_h = quo_h - ((8'(quo_k) << 3) + (8'(quo_k) << 1));
  assign diff_t = quo_t - ((11'(quo_h) << 3) + (11'(quo_h) << 1));
  assign diff_o = number_value_i - ((14'(quo_t) << 3) + (14'(quo_t) << 1));
  assign dig_h  = diff_h[3:0];
  assign dig_t  = diff_t[3:0];
  assign dig_o  = diff_o[3:0];

  // Phase timing.
  logic [7:0] len_raw, phase_len, delay_inc;
  logic       delay_done;

  assign len_raw    = (phase_q == PH_ACK_REL || phase_q == PH_ACK_HIGH) ? short_delay_q
                                                                        : long_delay_q;
  assign phase_len  = (len_raw == 8'd0) ? 8'd1 : len_raw;
  assign delay_inc  = delay_q + 8'd1;
  assign delay_done = delay_inc >= phase_len;

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    byte_sel_d = byte_sel_q;
    delay_d    = delay_q;
    poll_d     = poll_q;
    data_cur_d = data_cur_q;
    count_d    = count_q;
    queue_d    = queue_q;
    timeout_d  = 1'b0;
    done_d     = 1'b0;
    rej_d      = 1'b0;
    busy_now   = (count_q != '0) || (phase_q != PH_IDLE);

    if (kind_i == KIND_TICK) begin
      // Timed phases advance the delay counter; entering a phase clears both counters.
      case (phase_q)
        PH_IDLE: begin
          if (count_q != '0) begin
            shift_d    = queue_q[0][15:8];
            data_cur_d = queue_q[0][7:0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              queue_d[i] = queue_q[i+1];
            end
            count_d    = count_q - CNT_W'(1);
            byte_sel_d = 1'b0;
            bit_cnt_d  = 3'd0;
            phase_d    = PH_START_A;
            delay_d    = 8'd0;
            poll_d     = 8'd0;
          end
        end
        PH_START_A, PH_START_B, PH_BIT_SETUP, PH_BIT_HIGH, PH_ACK_REL, PH_ACK_HIGH,
        PH_STOP_A: begin
          delay_d = delay_inc;
          if (delay_done) begin
            delay_d = 8'd0;
            poll_d  = 8'd0;
            case (phase_q)
              PH_START_A:   phase_d = PH_START_B;
              PH_START_B:   phase_d = PH_BIT_SETUP;
              PH_BIT_SETUP: phase_d = PH_BIT_HIGH;
              PH_BIT_HIGH:  phase_d = PH_BIT_LOW;
              PH_ACK_REL:   phase_d = PH_ACK_HIGH;
              PH_ACK_HIGH:  phase_d = PH_ACK_POLL;
              PH_STOP_A:    phase_d = PH_STOP_B;
              default:      phase_d = PH_IDLE;
            endcase
          end
        end
        PH_BIT_LOW: begin
          delay_d = delay_inc;
          if (delay_done) begin
            delay_d = 8'd0;
            poll_d  = 8'd0;
            if (bit_cnt_q == 3'd7) begin
              bit_cnt_d = 3'd0;
              phase_d   = PH_ACK_REL;
            end else begin
              bit_cnt_d = bit_cnt_q + 3'd1;
              shift_d   = {shift_q[6:0], 1'b0};
              phase_d   = PH_BIT_SETUP;
            end
          end
        end
        PH_ACK_POLL: begin
          if (!sda_sample_i) begin
            delay_d = 8'd0;
            poll_d  = 8'd0;
            if (!byte_sel_q) begin
              byte_sel_d = 1'b1;
              shift_d    = data_cur_q;
              bit_cnt_d  = 3'd0;
              phase_d    = PH_BIT_SETUP;
            end else begin
              phase_d = PH_STOP_A;
            end
          end else if (poll_q >= poll_limit_q) begin
            // No acknowledge in time: abandon the rest of this transaction.
            timeout_d = 1'b1;
            delay_d   = 8'd0;
            poll_d    = 8'd0;
            phase_d   = PH_STOP_A;
          end else begin
            poll_d = poll_q + 8'd1;
          end
        end
        PH_STOP_B: begin
          delay_d = delay_inc;
          if (delay_done) begin
            delay_d = 8'd0;
            poll_d  = 8'd0;
            phase_d = PH_IDLE;
            done_d  = (count_q == '0);
          end
        end
        default: begin
          delay_d = 8'd0;
          poll_d  = 8'd0;
          phase_d = PH_IDLE;
        end
      endcase
    end else if (busy_now) begin
      rej_d = 1'b1;
    end else begin
      // The queue is empty whenever a request is taken, so it always fills from the head.
      case (kind_i)
        KIND_RAW: begin
          queue_d[0] = {address_byte_i, data_byte_i};
          count_d    = CNT_W'(1);
        end
        KIND_NUMBER: begin
          queue_d[0] = {ADDR_DIG_THOUSANDS, seg_lookup(dig_k)};
          queue_d[1] = {ADDR_DIG_HUNDREDS, seg_lookup(dig_h)};
          queue_d[2] = {ADDR_DIG_TENS, seg_lookup(dig_t)};
          queue_d[3] = {ADDR_DIG_ONES, seg_lookup(dig_o)};
          count_d    = CNT_W'(NUM_DIGITS);
        end
        KIND_BRIGHT: begin
          queue_d[0] = {ADDR_CONTROL, 1'b0, brightness_level_i, CONTROL_LOW_BITS};
          count_d    = CNT_W'(1);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end

    case (phase_d)
      PH_START_B:  begin res_d.scl_level = 1'b1; res_d.sda_release = 1'b0;       end
      PH_BIT_SETUP,
      PH_BIT_LOW:  begin res_d.scl_level = 1'b0; res_d.sda_release = shift_d[7]; end
      PH_BIT_HIGH: begin res_d.scl_level = 1'b1; res_d.sda_release = shift_d[7]; end
      PH_ACK_REL:  begin res_d.scl_level = 1'b0; res_d.sda_release = 1'b1;       end
      PH_STOP_A:   begin res_d.scl_level = 1'b0; res_d.sda_release = 1'b0;       end
      PH_STOP_B:   begin res_d.scl_level = 1'b1; res_d.sda_release = 1'b0;       end
      default:     begin res_d.scl_level = 1'b1; res_d.sda_release = 1'b1;       end
    endcase
    res_d.busy_res     = (count_d != '0) || (phase_d != PH_IDLE);
    res_d.ack_timeout  = timeout_d;
    res_d.request_done = done_d;
    res_d.rejected     = rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_delay_q <= SHORT_DELAY_RST;
      long_delay_q  <= LONG_DELAY_RST;
      poll_limit_q  <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHORT_DELAY: short_delay_q <= cfg_data_i;
        CFG_LONG_DELAY:  long_delay_q  <= cfg_data_i;
        CFG_POLL_LIMIT:  poll_limit_q  <= cfg_data_i;
        default:         poll_limit_q  <= poll_limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 3'd0;
      shift_q    <= 8'd0;
      byte_sel_q <= 1'b0;
      delay_q    <= 8'd0;
      poll_q     <= 8'd0;
      data_cur_q <= 8'd0;
      count_q    <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      byte_sel_q <= byte_sel_d;
      delay_q    <= delay_d;
      poll_q     <= poll_d;
      data_cur_q <= data_cur_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q <= queue_d;
    end
  end

  // Output word register with a one-word skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = out_q.scl_level;
  assign sda_release_o  = out_q.sda_release;
  assign busy_res_o     = out_q.busy_res;
  assign ack_timeout_o  = out_q.ack_timeout;
  assign request_done_o = out_q.request_done;
  assign rejected_o     = out_q.rejected;

`ifndef SYNTH
  // A full skid stage always sits behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A rejected request and a poll timeout come from different item kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ack_timeout_o && rejected_o))
    else $error("timeout and reject flagged in one word");

  // A tick with nothing queued keeps the bus idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_TICK && phase_q == PH_IDLE && count_q == '0)
      |=> phase_q == PH_IDLE)
    else $error("bus left idle with an empty queue");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import led2w_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // Digit d sits at bits [8*d +: 8].
  localparam logic [79:0] SEGMENT_ROM = {8'hD7, 8'hF7, 8'h85, 8'h77, 8'h57,
                                         8'hC6, 8'h97, 8'hB3, 8'h84, 8'hF5};

  typedef enum logic [1:0] {ACK_MIXED, ACK_ALWAYS, ACK_NEVER} ack_plan_e;

  class display_scoreboard;
    phase_e      phase;
    logic [2:0]  bit_cnt;
    logic [7:0]  shift_q;
    logic [7:0]  data_q;
    logic        byte_sel;
    logic [7:0]  dly_cnt;
    logic [7:0]  poll_cnt;
    logic [15:0] pairs[$];
    logic [7:0]  short_d;
    logic [7:0]  long_d;
    logic [7:0]  poll_lim;
    result_t     want_q[$];
    int          errors;

    function new();
      phase    = PH_IDLE;
      bit_cnt  = '0;
      shift_q  = '0;
      data_q   = '0;
      byte_sel = 1'b0;
      dly_cnt  = '0;
      poll_cnt = '0;
      short_d  = SHORT_DELAY_RST;
      long_d   = LONG_DELAY_RST;
      poll_lim = POLL_LIMIT_RST;
      errors   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        CFG_SHORT_DELAY: short_d = v;
        CFG_LONG_DELAY:  long_d = v;
        CFG_POLL_LIMIT:  poll_lim = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return pairs.size() != 0 || phase != PH_IDLE;
    endfunction

    function int outstanding();
      return want_q.size();
    endfunction

    function void go(phase_e p);
      phase    = p;
      dly_cnt  = '0;
      poll_cnt = '0;
    endfunction

    // A delay register of zero still holds the phase for one tick.
    function bit hold_expired();
      logic [7:0] n;
      n = (phase == PH_ACK_REL || phase == PH_ACK_HIGH) ? short_d : long_d;
      if (n == 8'd0) n = 8'd1;
      dly_cnt = dly_cnt + 8'd1;
      return dly_cnt >= n;
    endfunction

    function void queue_pair(logic [7:0] a, logic [7:0] d);
      if (pairs.size() < QDEPTH) pairs.push_back({a, d});
    endfunction

    function logic [7:0] segment_of(int digit);
      return SEGMENT_ROM[digit*8 +: 8];
    endfunction

    function void advance_bus(logic sda, output bit tmo, output bit done);
      logic [15:0] pair;
      tmo  = 1'b0;
      done = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (pairs.size() != 0) begin
            pair     = pairs.pop_front();
            shift_q  = pair[15:8];
            data_q   = pair[7:0];
            byte_sel = 1'b0;
            bit_cnt  = '0;
            go(PH_START_A);
          end
        end
        PH_START_A:   if (hold_expired()) go(PH_START_B);
        PH_START_B:   if (hold_expired()) go(PH_BIT_SETUP);
        PH_BIT_SETUP: if (hold_expired()) go(PH_BIT_HIGH);
        PH_BIT_HIGH:  if (hold_expired()) go(PH_BIT_LOW);
        PH_BIT_LOW: begin
          if (hold_expired()) begin
            if (bit_cnt == 3'd7) begin
              bit_cnt = '0;
              go(PH_ACK_REL);
            end else begin
              bit_cnt = bit_cnt + 3'd1;
              shift_q = shift_q << 1;
              go(PH_BIT_SETUP);
            end
          end
        end
        PH_ACK_REL:  if (hold_expired()) go(PH_ACK_HIGH);
        PH_ACK_HIGH: if (hold_expired()) go(PH_ACK_POLL);
        PH_ACK_POLL: begin
          if (!sda) begin
            if (!byte_sel) begin
              byte_sel = 1'b1;
              shift_q  = data_q;
              bit_cnt  = '0;
              go(PH_BIT_SETUP);
            end else begin
              go(PH_STOP_A);
            end
          end else if (poll_cnt >= poll_lim) begin
            // Timeout drops the rest of this transaction only.
            tmo = 1'b1;
            go(PH_STOP_A);
          end else begin
            poll_cnt = poll_cnt + 8'd1;
          end
        end
        PH_STOP_A: if (hold_expired()) go(PH_STOP_B);
        PH_STOP_B: begin
          if (hold_expired()) begin
            go(PH_IDLE);
            if (pairs.size() == 0) done = 1'b1;
          end
        end
        default: go(PH_IDLE);
      endcase
    endfunction

    function void note_word(logic [1:0] kind, logic [7:0] addr, logic [7:0] data,
                            logic [13:0] num, logic [2:0] lvl, logic sda);
      result_t w;
      bit      was_busy;
      bit      tmo;
      bit      done;
      int      n;
      w        = '0;
      tmo      = 1'b0;
      done     = 1'b0;
      n        = num;
      was_busy = busy();
      if (kind == KIND_TICK) begin
        advance_bus(sda, tmo, done);
      end else if (was_busy) begin
        w.rejected = 1'b1;
      end else if (kind == KIND_RAW) begin
        queue_pair(addr, data);
      end else if (kind == KIND_NUMBER) begin
        queue_pair(ADDR_DIG_THOUSANDS, segment_of((n / 1000) % 10));
        queue_pair(ADDR_DIG_HUNDREDS, segment_of((n / 100) % 10));
        queue_pair(ADDR_DIG_TENS, segment_of((n / 10) % 10));
        queue_pair(ADDR_DIG_ONES, segment_of(n % 10));
      end else begin
        queue_pair(ADDR_CONTROL, {1'b0, lvl, CONTROL_LOW_BITS});
      end
      case (phase)
        PH_START_B: begin
          w.scl_level = 1'b1;  w.sda_release = 1'b0;
        end
        PH_BIT_SETUP, PH_BIT_LOW: begin
          w.scl_level = 1'b0;  w.sda_release = shift_q[7];
        end
        PH_BIT_HIGH: begin
          w.scl_level = 1'b1;  w.sda_release = shift_q[7];
        end
        PH_ACK_REL: begin
          w.scl_level = 1'b0;  w.sda_release = 1'b1;
        end
        PH_STOP_A: begin
          w.scl_level = 1'b0;  w.sda_release = 1'b0;
        end
        PH_STOP_B: begin
          w.scl_level = 1'b1;  w.sda_release = 1'b0;
        end
        default: begin
          w.scl_level = 1'b1;  w.sda_release = 1'b1;
        end
      endcase
      w.busy_res     = busy();
      w.ack_timeout  = tmo;
      w.request_done = done;
      want_q.push_back(w);
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %0b actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (want_q.size() == 0) begin
        $display("%0t result word with nothing expected: actual %b", $time, got);
        errors++;
        return;
      end
      want = want_q.pop_front();
      compare_bit("scl_level", want.scl_level, got.scl_level);
      compare_bit("sda_release", want.sda_release, got.sda_release);
      compare_bit("busy_res", want.busy_res, got.busy_res);
      compare_bit("ack_timeout", want.ack_timeout, got.ack_timeout);
      compare_bit("request_done", want.request_done, got.request_done);
      compare_bit("rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [7:0]  addr_b;
  logic [7:0]  data_b;
  logic [13:0] number_v;
  logic [2:0]  bright_lvl;
  logic        sda_s;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_lvl;
  logic        sda_rel;
  logic        busy_flag;
  logic        timeout_flag;
  logic        done_flag;
  logic        reject_flag;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  display_scoreboard sb;
  ack_plan_e   ack_plan;
  bit          plan_armed;
  int          polls_sent;
  int          ack_after;
  bit          quiet_run = 1'b0;
  int          recv_left = 0;
  int unsigned cycles = 0;

  led_display_two_wire_writer #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (kind),
    .address_byte_i     (addr_b),
    .data_byte_i        (data_b),
    .number_value_i     (number_v),
    .brightness_level_i (bright_lvl),
    .sda_sample_i       (sda_s),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .scl_level_o        (scl_lvl),
    .sda_release_o      (sda_rel),
    .busy_res_o         (busy_flag),
    .ack_timeout_o      (timeout_flag),
    .request_done_o     (done_flag),
    .rejected_o         (reject_flag),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_word(kind, addr_b, data_b, number_v, bright_lvl, sda_s);
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    got.scl_level    = scl_lvl;
    got.sda_release  = sda_rel;
    got.busy_res     = busy_flag;
    got.ack_timeout  = timeout_flag;
    got.request_done = done_flag;
    got.rejected     = reject_flag;
    if (rst_n && out_valid && !out_stall) sb.check_word(got);
  end

  // Receiver stalls come in bursts; none once the quiet stretch begins.
  always @(negedge clk) begin
    if (recv_left == 0 && !quiet_run && $urandom_range(0, 7) == 0)
      recv_left = $urandom_range(1, 14);
    if (recv_left > 0) begin
      out_stall = 1'b1;
      recv_left = recv_left - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Line level offered on the next tick. During an acknowledge poll it follows
  // the current plan: acknowledge at once, after a few failed polls, or never.
  function logic next_sda();
    if (sb.phase != PH_ACK_POLL) begin
      plan_armed = 1'b0;
      return 1'($urandom_range(0, 1));
    end
    if (!plan_armed) begin
      plan_armed = 1'b1;
      polls_sent = 0;
      case (ack_plan)
        ACK_ALWAYS: ack_after = 0;
        ACK_NEVER:  ack_after = 1000;
        default:    ack_after = ($urandom_range(0, 6) == 0) ? 1000 : $urandom_range(0, 3);
      endcase
    end
    polls_sent++;
    return (polls_sent > ack_after) ? 1'b0 : 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_word(logic [1:0] k, logic [7:0] a, logic [7:0] d,
                            logic [13:0] nv, logic [2:0] lv, logic s);
    in_valid   = 1'b1;
    kind       = k;
    addr_b     = a;
    data_b     = d;
    number_v   = nv;
    bright_lvl = lv;
    sda_s      = s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic idle_sender(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!quiet_run && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 14));
  endtask

  task automatic send_tick();
    maybe_idle();
    drive_word(KIND_TICK, 8'($urandom), 8'($urandom), 14'($urandom), 3'($urandom),
               next_sda());
  endtask

  task automatic send_request(logic [1:0] k, logic [7:0] a, logic [7:0] d,
                              logic [13:0] nv, logic [2:0] lv);
    maybe_idle();
    drive_word(k, a, d, nv, lv, 1'($urandom_range(0, 1)));
  endtask

  task automatic tick_until_idle();
    while (sb.busy()) send_tick();
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [7:0] short_v, logic [7:0] long_v, logic [7:0] poll_v);
    drain();
    write_reg(CFG_SHORT_DELAY, short_v);
    write_reg(CFG_LONG_DELAY, long_v);
    write_reg(CFG_POLL_LIMIT, poll_v);
  endtask

  // Requests go in mostly while idle so that transactions run to the end;
  // a few land while busy and are turned away.
  task automatic random_phase(int target, bit pause_midway);
    int         counted;
    bit         was_busy;
    bit         paused;
    logic [1:0] k;
    logic [13:0] nv;
    counted = 0;
    paused  = 1'b0;
    while (counted < target) begin
      if (pause_midway && !paused && counted >= target / 2) begin
        paused = 1'b1;
        drain();
      end
      was_busy = sb.busy();
      if (was_busy ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 2) == 0)) begin
        k  = 2'($urandom_range(1, 3));
        nv = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(10000, 16383))
                                         : 14'($urandom_range(0, 9999));
        send_request(k, 8'($urandom), 8'($urandom), nv, 3'($urandom));
        if (!was_busy) counted++;
      end else begin
        send_tick();
        if (was_busy) counted++;
      end
    end
    tick_until_idle();
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    kind       = KIND_TICK;
    addr_b     = '0;
    data_b     = '0;
    number_v   = '0;
    bright_lvl = '0;
    sda_s      = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SHORT_DELAY;
    cfg_data   = '0;
    ack_plan   = ACK_ALWAYS;
    plan_armed = 1'b0;
    polls_sent = 0;
    ack_after  = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Idle with an empty queue: the sampled line level must not matter.
    drive_word(KIND_TICK, 8'h00, 8'h00, 14'h0000, 3'd0, 1'b0);
    drive_word(KIND_TICK, 8'hFF, 8'hFF, 14'h3FFF, 3'd7, 1'b1);

    // Requests on top of a queued one are rejected.
    send_request(KIND_RAW, 8'h00, 8'h00, 14'd0, 3'd0);
    send_request(KIND_NUMBER, 8'hFF, 8'hFF, 14'd9999, 3'd7);
    send_request(KIND_BRIGHT, 8'hFF, 8'hFF, 14'd9999, 3'd7);
    tick_until_idle();
    ack_plan = ACK_NEVER;
    send_request(KIND_RAW, 8'hA5, 8'h5A, 14'd0, 3'd0);
    tick_until_idle();

    // Zero delays count as one tick; a zero poll limit times out on the first miss,
    // and the rest of the queued digits still go out.
    configure(8'd0, 8'd0, 8'd0);
    send_request(KIND_NUMBER, 8'h00, 8'h00, 14'd4321, 3'd0);
    tick_until_idle();
    ack_plan = ACK_ALWAYS;
    // Values above 9999 show only their lowest four decimal digits.
    send_request(KIND_NUMBER, 8'h00, 8'h00, 14'h3FFF, 3'd0);
    tick_until_idle();
    send_request(KIND_BRIGHT, 8'h00, 8'h00, 14'd0, 3'd7);
    repeat (30) send_tick();
    send_request(KIND_RAW, 8'h12, 8'h34, 14'd0, 3'd0);
    tick_until_idle();

    // The longest acknowledge phases, then a timeout on the address byte.
    configure(8'd255, 8'd1, 8'd0);
    ack_plan = ACK_NEVER;
    send_request(KIND_RAW, 8'h81, 8'h7E, 14'd0, 3'd0);
    tick_until_idle();

    ack_plan = ACK_MIXED;
    configure(8'd1, 8'd1, 8'd3);
    random_phase(80, 1'b1);
    configure(8'd2, 8'd3, 8'd12);
    random_phase(80, 1'b0);
    configure(8'd1, 8'd1, 8'd255);
    random_phase(80, 1'b0);
    configure(8'd3, 8'd2, 8'd1);
    random_phase(80, 1'b0);
    configure(8'd1, 8'd2, 8'd6);
    quiet_run = 1'b1;
    random_phase(80, 1'b0);
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
